// File: rtl/core/obiou_pkg.sv
// obiou_pkg: types, widths and constants for the oriented box iou pipeline
// holds the cordic arctangent table; no dependencies
package obiou_pkg;

  localparam int CW        = 33;  // cordic vector, q.30 plus guard
  localparam int ZW        = 20;  // cordic angle, q.16 signed
  localparam int TW        = 18;  // rounded cos/sin, q1.16 signed
  localparam int MW        = 17;  // |cos|, |sin|
  localparam int MPW       = 33;  // extent partial product
  localparam int CPW       = 36;  // cos a * cos b
  localparam int EW        = 18;  // half extent, 1/32 pixel
  localparam int BW        = 20;  // bound coordinate
  localparam int DXW       = 19;  // overlap length
  localparam int PW        = 38;  // dx * dy
  localparam int FW        = 17;  // cosine factor, q.16
  localparam int PFW       = 55;  // dx * dy * factor
  localparam int RW        = 33;  // divider remainder and union
  localparam int NUMW      = 49;  // iou dividend
  localparam int QW        = 17;  // iou quotient
  localparam int DIV_STEPS = 17;

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CW-1:0] TRIG_ONE     = 33'sd65536;
  localparam logic signed [ZW-1:0] PI_Q16       = 20'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16  = 20'sd102944;
  localparam logic [31:0]          OVL_MAX      = 32'hFFFE_0001;
  localparam logic [QW-1:0]        IOU_ONE      = 17'h10000;
  localparam logic [FW-1:0]        FACTOR_MIN   = 17'd32768;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        w;
    logic [15:0]        h;
  } box_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [16:0]    lo;
    logic [RW-1:0]  u;
    logic [QW-1:0]  q;
    logic           ovf;
    logic           zero;
    logic [31:0]    ov;
    logic           apx;
  } div_t;

  function automatic logic [16:0] atan_q16(input int unsigned idx);
    logic [16:0] a;
    unique case (idx)
      0:       a = 17'd51472;
      1:       a = 17'd30386;
      2:       a = 17'd16055;
      3:       a = 17'd8150;
      4:       a = 17'd4091;
      5:       a = 17'd2047;
      6:       a = 17'd1024;
      7:       a = 17'd512;
      8:       a = 17'd256;
      9:       a = 17'd128;
      10:      a = 17'd64;
      11:      a = 17'd32;
      12:      a = 17'd16;
      13:      a = 17'd8;
      14:      a = 17'd4;
      15:      a = 17'd2;
      16:      a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/oriented_box_iou_approx_top.sv
// throughput: one box pair per cycle while no valid result is held by out_stall;
// one cordic iteration and one quotient bit per stage
// the divider's 17 restoring steps and the cordic chain set the depth
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset (rst_n, synchronous, active low) clears the valid bits only
module oriented_box_iou_approx_top
  import obiou_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_a_center_x,
  input  logic signed [15:0] in_a_center_y,
  input  logic [15:0]        in_a_width,
  input  logic [15:0]        in_a_height,
  input  logic signed [15:0] in_a_angle,
  input  logic signed [15:0] in_b_center_x,
  input  logic signed [15:0] in_b_center_y,
  input  logic [15:0]        in_b_width,
  input  logic [15:0]        in_b_height,
  input  logic signed [15:0] in_b_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_iou,
  output logic [31:0]        out_overlap_area,
  output logic               out_approximated
);

  localparam int N = TRIG_ITERATIONS;

  logic en;
  logic out_valid_r;
  logic [16:0] out_iou_r;
  logic [31:0] out_overlap_area_r;
  logic out_approximated_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  function automatic cordic_t reduce(input logic signed [15:0] ang);
    cordic_t c;
    logic signed [ZW-1:0] z;
    z = {ang[15], ang, 3'b000};
    c.x = INV_GAIN_Q30;
    c.y = '0;
    c.flip = 1'b0;
    if (z > HALF_PI_Q16) begin
      z = z - PI_Q16;
      c.flip = 1'b1;
    end else if (z < -HALF_PI_Q16) begin
      z = z + PI_Q16;
      c.flip = 1'b1;
    end
    c.z = z;
    return c;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] a;
    dx = c.y >>> i;
    dy = c.x >>> i;
    a  = $signed(ZW'(atan_q16(i)));
    n  = c;
    if (!c.z[ZW-1]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - a;
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + a;
    end
    return n;
  endfunction

  function automatic logic signed [TW-1:0] q30_round(input logic signed [CW-1:0] v,
                                                     input logic flip);
    logic signed [CW-1:0] r;
    logic signed [TW-1:0] t;
    r = (v + 33'sd8192) >>> 14;
    if (r > TRIG_ONE) r = TRIG_ONE;
    else if (r < -TRIG_ONE) r = -TRIG_ONE;
    t = $signed(r[TW-1:0]);
    if (flip) t = -t;
    return t;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] a;
    a = t[TW-1] ? -t : t;
    return a[MW-1:0];
  endfunction

  function automatic logic [DXW-1:0] overlap_1d(input logic signed [15:0] c1,
                                                input logic [EW-1:0] e1,
                                                input logic signed [15:0] c2,
                                                input logic [EW-1:0] e2);
    logic signed [BW-1:0] m1, m2, x1, x2, lo, hi, d;
    m1 = {{(BW-17){c1[15]}}, c1, 1'b0};
    m2 = {{(BW-17){c2[15]}}, c2, 1'b0};
    x1 = $signed({{(BW-EW){1'b0}}, e1});
    x2 = $signed({{(BW-EW){1'b0}}, e2});
    lo = (m1 - x1 > m2 - x2) ? m1 - x1 : m2 - x2;
    hi = (m1 + x1 < m2 + x2) ? m1 + x1 : m2 + x2;
    d  = (lo >= hi) ? '0 : hi - lo;
    return d[DXW-1:0];
  endfunction

  // ---- stage 0: capture and angle reduction
  cordic_t cda_r [0:N];
  cordic_t cdb_r [0:N];
  box_t    bxa_r [0:N];
  box_t    bxb_r [0:N];
  logic    apx_r [0:N];
  logic    cv_r  [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      cda_r[0] <= reduce(in_a_angle);
      cdb_r[0] <= reduce(in_b_angle);
      bxa_r[0] <= '{cx: in_a_center_x, cy: in_a_center_y, w: in_a_width, h: in_a_height};
      bxb_r[0] <= '{cx: in_b_center_x, cy: in_b_center_y, w: in_b_width, h: in_b_height};
      apx_r[0] <= (in_a_angle != 16'sd0) || (in_b_angle != 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_valid;
    end
  end

  // ---- cordic, one iteration per stage for both angles
  for (genvar k = 0; k < N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cda_r[k+1] <= cordic_step(cda_r[k], k);
        cdb_r[k+1] <= cordic_step(cdb_r[k], k);
        bxa_r[k+1] <= bxa_r[k];
        bxb_r[k+1] <= bxb_r[k];
        apx_r[k+1] <= apx_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (en) begin
        cv_r[k+1] <= cv_r[k];
      end
    end
  end

  // ---- stage r: round to q1.16
  logic signed [TW-1:0] tca_r, tsa_r, tcb_r, tsb_r;
  box_t rbxa_r, rbxb_r;
  logic rapx_r, rv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tca_r  <= q30_round(cda_r[N].x, cda_r[N].flip);
      tsa_r  <= q30_round(cda_r[N].y, cda_r[N].flip);
      tcb_r  <= q30_round(cdb_r[N].x, cdb_r[N].flip);
      tsb_r  <= q30_round(cdb_r[N].y, cdb_r[N].flip);
      rbxa_r <= bxa_r[N];
      rbxb_r <= bxb_r[N];
      rapx_r <= apx_r[N];
    end
  end

  // ---- stage m: extent products, cosine product, areas
  logic [MPW-1:0] awc_r, ahs_r, aws_r, ahc_r, bwc_r, bhs_r, bws_r, bhc_r;
  logic signed [CPW-1:0] cp_r;
  logic [31:0] area_a_r, area_b_r;
  box_t mbxa_r, mbxb_r;
  logic mapx_r, mv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      awc_r    <= MPW'(rbxa_r.w) * MPW'(mag(tca_r));
      ahs_r    <= MPW'(rbxa_r.h) * MPW'(mag(tsa_r));
      aws_r    <= MPW'(rbxa_r.w) * MPW'(mag(tsa_r));
      ahc_r    <= MPW'(rbxa_r.h) * MPW'(mag(tca_r));
      bwc_r    <= MPW'(rbxb_r.w) * MPW'(mag(tcb_r));
      bhs_r    <= MPW'(rbxb_r.h) * MPW'(mag(tsb_r));
      bws_r    <= MPW'(rbxb_r.w) * MPW'(mag(tsb_r));
      bhc_r    <= MPW'(rbxb_r.h) * MPW'(mag(tcb_r));
      cp_r     <= CPW'(tca_r) * CPW'(tcb_r);
      area_a_r <= 32'(rbxa_r.w) * 32'(rbxa_r.h);
      area_b_r <= 32'(rbxb_r.w) * 32'(rbxb_r.h);
      mbxa_r   <= rbxa_r;
      mbxb_r   <= rbxb_r;
      mapx_r   <= rapx_r;
    end
  end

  // ---- stage e: half extents and cosine factor
  logic [EW-1:0] eax_r, eay_r, ebx_r, eby_r;
  logic [FW-1:0] f_r;
  logic signed [15:0] ecax_r, ecay_r, ecbx_r, ecby_r;
  logic [31:0] earea_a_r, earea_b_r;
  logic eapx_r, ev_r;

  logic [MPW:0] sax, say, sbx, sby;
  logic signed [CPW-1:0] cpr;

  always_comb begin
    sax = (MPW+1)'(awc_r) + (MPW+1)'(ahs_r) + (MPW+1)'(32768);
    say = (MPW+1)'(aws_r) + (MPW+1)'(ahc_r) + (MPW+1)'(32768);
    sbx = (MPW+1)'(bwc_r) + (MPW+1)'(bhs_r) + (MPW+1)'(32768);
    sby = (MPW+1)'(bws_r) + (MPW+1)'(bhc_r) + (MPW+1)'(32768);
    cpr = (cp_r + 36'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eax_r     <= mapx_r ? sax[MPW:16] : EW'(mbxa_r.w);
      eay_r     <= mapx_r ? say[MPW:16] : EW'(mbxa_r.h);
      ebx_r     <= mapx_r ? sbx[MPW:16] : EW'(mbxb_r.w);
      eby_r     <= mapx_r ? sby[MPW:16] : EW'(mbxb_r.h);
      // factor is round(cos a * cos b), floored at one half
      f_r       <= (cp_r >= 36'sd2147483648) ? cpr[FW-1:0] : FACTOR_MIN;
      ecax_r    <= mbxa_r.cx;
      ecay_r    <= mbxa_r.cy;
      ecbx_r    <= mbxb_r.cx;
      ecby_r    <= mbxb_r.cy;
      earea_a_r <= area_a_r;
      earea_b_r <= area_b_r;
      eapx_r    <= mapx_r;
    end
  end

  // ---- stage o: overlap of bounds
  logic [DXW-1:0] dx_r, dy_r;
  logic [FW-1:0] of_r;
  logic [31:0] oarea_a_r, oarea_b_r;
  logic oapx_r, ov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= overlap_1d(ecax_r, eax_r, ecbx_r, ebx_r);
      dy_r      <= overlap_1d(ecay_r, eay_r, ecby_r, eby_r);
      of_r      <= f_r;
      oarea_a_r <= earea_a_r;
      oarea_b_r <= earea_b_r;
      oapx_r    <= eapx_r;
    end
  end

  // ---- stage p: dx * dy
  logic [PW-1:0] p_r;
  logic [FW-1:0] pf_f_r;
  logic [31:0] parea_a_r, parea_b_r;
  logic papx_r, pv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r       <= PW'(dx_r) * PW'(dy_r);
      pf_f_r    <= of_r;
      parea_a_r <= oarea_a_r;
      parea_b_r <= oarea_b_r;
      papx_r    <= oapx_r;
    end
  end

  // ---- stage q: times cosine factor
  logic [PFW-1:0] pf_r;
  logic [PW-1:0] qp_r;
  logic [31:0] qarea_a_r, qarea_b_r;
  logic qapx_r, qv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pf_r      <= PFW'(p_r) * PFW'(pf_f_r);
      qp_r      <= p_r;
      qarea_a_r <= parea_a_r;
      qarea_b_r <= parea_b_r;
      qapx_r    <= papx_r;
    end
  end

  // ---- stage v: round to q32.0 and saturate
  logic [31:0] vov_r;
  logic [31:0] varea_a_r, varea_b_r;
  logic vapx_r, vv_r;

  logic [PFW-1:0] pfr;
  logic [PW-1:0]  pr;
  logic [36:0]    ovw;

  always_comb begin
    pfr = pf_r + PFW'(131072);
    pr  = qp_r + PW'(2);
    ovw = qapx_r ? pfr[PFW-1:18] : {1'b0, pr[PW-1:2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vov_r     <= (ovw > 37'(OVL_MAX)) ? OVL_MAX : ovw[31:0];
      varea_a_r <= qarea_a_r;
      varea_b_r <= qarea_b_r;
      vapx_r    <= qapx_r;
    end
  end

  // ---- stage u: union
  logic signed [RW:0] uni;
  logic [RW-1:0] uu_r;
  logic uzero_r;
  logic [31:0] uov_r;
  logic uapx_r, uv_r;

  assign uni = $signed({2'b00, varea_a_r}) + $signed({2'b00, varea_b_r})
             - $signed({2'b00, vov_r});

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r    <= uni[RW-1:0];
      // negative or zero union
      uzero_r <= uni[RW] || (uni[RW-1:0] == '0);
      uov_r   <= vov_r;
      uapx_r  <= vapx_r;
    end
  end

  // ---- stage n: dividend and overflow check, feeds divider
  div_t dv_r  [0:DIV_STEPS];
  logic dvv_r [0:DIV_STEPS];
  logic [NUMW-1:0] num;

  assign num = NUMW'({uov_r, 16'h0000}) + NUMW'(uu_r >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].rem  <= {1'b0, num[NUMW-1:17]};
      dv_r[0].lo   <= num[16:0];
      dv_r[0].u    <= uu_r;
      dv_r[0].q    <= '0;
      // quotient of 2^17 or more saturates anyway
      dv_r[0].ovf  <= {1'b0, num[NUMW-1:17]} >= uu_r;
      dv_r[0].zero <= uzero_r;
      dv_r[0].ov   <= uov_r;
      dv_r[0].apx  <= uapx_r;
    end
  end

  // ---- restoring divider, one quotient bit per stage
  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    logic [RW:0] t;
    logic [RW:0] diff;
    div_t nx;
    always_comb begin
      t    = {dv_r[d].rem, dv_r[d].lo[16]};
      diff = t - {1'b0, dv_r[d].u};
      nx   = dv_r[d];
      nx.lo = {dv_r[d].lo[15:0], 1'b0};
      if (t >= {1'b0, dv_r[d].u}) begin
        nx.rem = diff[RW-1:0];
        nx.q   = {dv_r[d].q[QW-2:0], 1'b1};
      end else begin
        nx.rem = t[RW-1:0];
        nx.q   = {dv_r[d].q[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[d+1] <= nx;
      end
    end
  end

  // ---- valid bits for the stages after the cordic chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      mv_r <= 1'b0;
      ev_r <= 1'b0;
      ov_r <= 1'b0;
      pv_r <= 1'b0;
      qv_r <= 1'b0;
      vv_r <= 1'b0;
      uv_r <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) dvv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      rv_r <= cv_r[N];
      mv_r <= rv_r;
      ev_r <= mv_r;
      ov_r <= ev_r;
      pv_r <= ov_r;
      qv_r <= pv_r;
      vv_r <= qv_r;
      uv_r <= vv_r;
      dvv_r[0] <= uv_r;
      for (int i = 0; i < DIV_STEPS; i++) dvv_r[i+1] <= dvv_r[i];
      out_valid_r <= dvv_r[DIV_STEPS];
    end
  end

  // ---- output register
  div_t fin;
  logic [16:0] iou_nxt;

  always_comb begin
    fin = dv_r[DIV_STEPS];
    priority if (fin.zero) begin
      iou_nxt = '0;
    end else if (fin.ovf || fin.q > IOU_ONE) begin
      iou_nxt = IOU_ONE;
    end else begin
      iou_nxt = fin.q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_iou_r          <= iou_nxt;
      out_overlap_area_r <= fin.ov;
      out_approximated_r <= fin.apx;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_iou          = out_iou_r;
  assign out_overlap_area = out_overlap_area_r;
  assign out_approximated = out_approximated_r;

  a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_iou_r <= IOU_ONE)
    else $error("iou above one");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cv_r[0]) && $stable(dvv_r[DIV_STEPS]) && $stable(out_iou_r))
    else $error("pipeline moved while stalled");

  a_zero_union: assert property (@(posedge clk) disable iff (!rst_n)
    dvv_r[DIV_STEPS] && dv_r[DIV_STEPS].zero && en |=> out_iou_r == '0)
    else $error("nonzero iou for empty union");

endmodule

// File: bench/tb_oriented_box_iou_approx_top.sv
// testbench for oriented_box_iou_approx_top: box pair requests in, iou results out
// depends on obiou_pkg and the top module; expected results come from a local predictor
module tb_oriented_box_iou_approx_top;
  import obiou_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [15:0] ang;
  } obox_t;

  typedef struct {
    logic [16:0] iou;
    logic [31:0] ov;
    logic        apx;
  } iou_res_t;

  localparam longint OVL_SAT = 64'd4294836225;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_a_center_x = '0, in_a_center_y = '0;
  logic [15:0] in_a_width = '0, in_a_height = '0;
  logic signed [15:0] in_a_angle = '0;
  logic signed [15:0] in_b_center_x = '0, in_b_center_y = '0;
  logic [15:0] in_b_width = '0, in_b_height = '0;
  logic signed [15:0] in_b_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_iou;
  logic [31:0] out_overlap_area;
  logic out_approximated;

  iou_res_t expected_iou_q[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  bit idling_on = 1'b1;
  bit hold_req = 1'b0;

  oriented_box_iou_approx_top DUT (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_a_center_x, .in_a_center_y, .in_a_width, .in_a_height, .in_a_angle,
    .in_b_center_x, .in_b_center_y, .in_b_width, .in_b_height, .in_b_angle,
    .out_valid, .out_stall, .out_iou, .out_overlap_area, .out_approximated
  );

  always #10 clk = ~clk;

  function automatic int atan_tab(input int i);
    int t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? t[i] : 0;
  endfunction

  // cordic cos/sin in q1.16, with pi reduction
  function automatic void cordic_cos_sin(input logic signed [15:0] ang, output longint c,
                                         output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 8;
    flip = 1'b0;
    x = 64'd652032874;
    y = 0;
    if (z > 102944) begin
      z -= 205887;
      flip = 1'b1;
    end else if (z < -102944) begin
      z += 205887;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tab(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_tab(i));
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (s > 65536) s = 65536;
    if (s < -65536) s = -65536;
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic longint span_overlap(input longint c1, input longint e1,
                                          input longint c2, input longint e2);
    longint lo, hi;
    lo = (2*c1 - e1 > 2*c2 - e2) ? 2*c1 - e1 : 2*c2 - e2;
    hi = (2*c1 + e1 < 2*c2 + e2) ? 2*c1 + e1 : 2*c2 + e2;
    return (lo >= hi) ? 0 : hi - lo;
  endfunction

  function automatic iou_res_t predict_iou(input obox_t a, input obox_t b);
    iou_res_t r;
    longint ca, sa, cb, sb, aex, aey, bex, bey, dx, dy, cp, f, ov, uni, iou;
    r.apx = (a.ang != 0) || (b.ang != 0);
    if (!r.apx) begin
      dx = span_overlap(a.cx, a.w, b.cx, b.w);
      dy = span_overlap(a.cy, a.h, b.cy, b.h);
      ov = (dx * dy + 2) >> 2;
    end else begin
      cordic_cos_sin(a.ang, ca, sa);
      cordic_cos_sin(b.ang, cb, sb);
      if (ca < 0) ca = -ca;
      if (sa < 0) sa = -sa;
      aex = (longint'(a.w) * ca + longint'(a.h) * sa + 32768) >> 16;
      aey = (longint'(a.w) * sa + longint'(a.h) * ca + 32768) >> 16;
      begin
        longint acb, asb;
        acb = (cb < 0) ? -cb : cb;
        asb = (sb < 0) ? -sb : sb;
        bex = (longint'(b.w) * acb + longint'(b.h) * asb + 32768) >> 16;
        bey = (longint'(b.w) * asb + longint'(b.h) * acb + 32768) >> 16;
      end
      dx = span_overlap(a.cx, aex, b.cx, bex);
      dy = span_overlap(a.cy, aey, b.cy, bey);
      // sign of the product matters, so the raw cosines are needed here
      cordic_cos_sin(a.ang, ca, sa);
      cp = ca * cb;
      f = (cp >= 64'sd2147483648) ? (cp + 32768) >>> 16 : 32768;
      ov = (dx * dy * f + 131072) >> 18;
    end
    if (ov > OVL_SAT) ov = OVL_SAT;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - ov;
    iou = 0;
    if (uni > 0) begin
      iou = (ov * 65536 + uni / 2) / uni;
      if (iou > 65536) iou = 65536;
    end
    r.iou = iou[16:0];
    r.ov = ov[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  // one request; valid stays high unless a gap follows
  task automatic send_pair(input obox_t a, input obox_t b);
    in_valid <= 1'b1;
    in_a_center_x <= a.cx; in_a_center_y <= a.cy;
    in_a_width <= a.w; in_a_height <= a.h; in_a_angle <= a.ang;
    in_b_center_x <= b.cx; in_b_center_y <= b.cy;
    in_b_width <= b.w; in_b_height <= b.h; in_b_angle <= b.ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_iou_q.push_back(predict_iou(a, b));
    pairs_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_iou_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic obox_t mk_box(input int cx, input int cy, input int w, input int h,
                                   input int ang);
    obox_t o;
    o.cx = 16'(cx); o.cy = 16'(cy); o.w = 16'(w); o.h = 16'(h); o.ang = 16'(ang);
    return o;
  endfunction

  function automatic obox_t rand_box(input bit rot);
    obox_t o;
    o.cx = 16'($urandom_range(0, 8000) - 4000);
    o.cy = 16'($urandom_range(0, 8000) - 4000);
    o.w = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000));
    o.h = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000));
    o.ang = rot ? 16'($urandom_range(0, 51472) - 25736) : 16'sd0;
    return o;
  endfunction

  // query box placed near the first so the bounds mostly overlap
  function automatic obox_t near_box(input obox_t a, input bit rot);
    obox_t o;
    o = rand_box(rot);
    o.cx = 16'(a.cx + $signed($urandom_range(0, 1600)) - 800);
    o.cy = 16'(a.cy + $signed($urandom_range(0, 1600)) - 800);
    return o;
  endfunction

  function automatic obox_t noise_box();
    obox_t o;
    o.cx = 16'($urandom); o.cy = 16'($urandom); o.w = 16'($urandom);
    o.h = 16'($urandom); o.ang = 16'($urandom);
    return o;
  endfunction

  task automatic test_directed();
    obox_t z, big;
    z = mk_box(0, 0, 0, 0, 0);
    big = mk_box(0, 0, 65535, 65535, 0);
    send_pair(z, z);                              // empty union
    send_pair(big, big);                          // largest exact overlap
    send_pair(mk_box(-32768, -32768, 65535, 65535, 0), mk_box(32767, 32767, 65535, 65535, 0));
    send_pair(mk_box(0, 0, 65535, 65535, 6434), big);  // rotated box over the largest box
    send_pair(mk_box(100, 100, 800, 400, 3000), mk_box(100, 100, 800, 400, 3000));
    send_pair(mk_box(0, 0, 800, 400, 12868), mk_box(0, 0, 800, 400, 12869));
    send_pair(mk_box(0, 0, 800, 400, -12868), mk_box(0, 0, 800, 400, -12869));
    send_pair(mk_box(0, 0, 800, 400, 25736), mk_box(10, 0, 800, 400, -25736));
    send_pair(mk_box(0, 0, 800, 400, 32767), mk_box(10, 0, 800, 400, -32768));
    send_pair(mk_box(0, 0, 0, 400, 1000), mk_box(0, 0, 800, 0, 0));
    send_pair(mk_box(0, 0, 800, 400, 0), mk_box(200, 0, 800, 400, 1));
    send_pair(mk_box(0, 0, 800, 400, 0), mk_box(800, 0, 800, 400, 0));  // touching edges
    send_pair(mk_box(0, 0, 800, 400, 0), mk_box(5000, 5000, 800, 400, 0));
    send_pair(mk_box(32767, -32768, 1, 1, 0), mk_box(32767, -32768, 1, 1, 0));
    send_pair(mk_box(0, 0, 1000, 200, 12868), mk_box(0, 0, 1000, 200, -12868));  // low factor
    wait_drained();
  endtask

  task automatic test_exact_random(input int n);
    obox_t a;
    repeat (n) begin
      a = rand_box(1'b0);
      send_pair(a, near_box(a, 1'b0));
    end
  endtask

  task automatic test_rotated_random(input int n);
    obox_t a, b;
    repeat (n) begin
      a = rand_box($urandom_range(0, 3) != 0);
      b = near_box(a, $urandom_range(0, 3) != 0);
      if (a.ang == 0 && b.ang == 0) b.ang = 16'($urandom_range(1, 25736));
      send_pair(a, b);
    end
  endtask

  task automatic test_noise(input int n);
    repeat (n) send_pair(noise_box(), noise_box());
  endtask

  task automatic test_backpressure(input int n);
    obox_t a;
    hold_req = 1'b1;
    repeat (n) begin
      a = rand_box(1'b1);
      send_pair(a, near_box(a, 1'b1));
    end
    wait_drained();
  endtask

  task automatic test_no_idle(input int n);
    obox_t a;
    idling_on = 1'b0;
    repeat (n) begin
      a = rand_box($urandom_range(0, 1));
      send_pair(a, near_box(a, $urandom_range(0, 1)));
    end
  endtask

  // receiver: random stall bursts, one long hold on request, none at the end
  initial begin
    int left;
    bit stall_now;
    left = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        left = 0;
      end else if (!idling_on || !rst_n) begin
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          left = stall_now ? $urandom_range(1, 14) : $urandom_range(1, 40);
        end
        out_stall <= stall_now;
        left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_iou_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        iou_res_t e;
        e = expected_iou_q.pop_front();
        results_seen++;
        if (out_iou !== e.iou) report_mismatch("iou", out_iou, e.iou);
        if (out_overlap_area !== e.ov) report_mismatch("overlap_area", out_overlap_area, e.ov);
        if (out_approximated !== e.apx)
          report_mismatch("approximated", out_approximated, e.apx);
      end
    end
  end

  initial begin
    #10ms;
    $display("timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_exact_random(350);
    test_rotated_random(400);
    test_noise(150);
    test_backpressure(120);
    test_rotated_random(100);
    wait_drained();   // sender pauses until every result is back
    test_no_idle(200);
    wait_drained();
    if (expected_iou_q.size() != 0) report_mismatch("results left over", 0,
                                                   expected_iou_q.size());
    $display("sent %0d box pairs (exact, rotated, noise, back-pressure), checked %0d results",
             pairs_sent, results_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
